>>> hdl/srvm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// srvm_pkg
// Opcodes, error codes, sizes and state codes of the stack/register VM.
// ----------------------------------------------------------------------------
package srvm_pkg;

  localparam int STACK_DEPTH_DEF = 16384;
  localparam int NUM_REGS_DEF    = 32;

  localparam logic [5:0] OP_HALT  = 6'd0;
  localparam logic [5:0] OP_DISP  = 6'd1;
  localparam logic [5:0] OP_PSTK  = 6'd2;
  localparam logic [5:0] OP_PUSH  = 6'd10;
  localparam logic [5:0] OP_POP   = 6'd11;
  localparam logic [5:0] OP_MOV   = 6'd12;
  localparam logic [5:0] OP_CALL  = 6'd20;
  localparam logic [5:0] OP_RET   = 6'd21;
  localparam logic [5:0] OP_JMP   = 6'd22;
  localparam logic [5:0] OP_JZ    = 6'd23;
  localparam logic [5:0] OP_JPOS  = 6'd24;
  localparam logic [5:0] OP_JNEG  = 6'd25;
  localparam logic [5:0] OP_ADD   = 6'd30;
  localparam logic [5:0] OP_SUB   = 6'd31;
  localparam logic [5:0] OP_MUL   = 6'd32;
  localparam logic [5:0] OP_DIV   = 6'd33;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_OVER   = 3'd1;
  localparam logic [2:0] ERR_UNDER  = 3'd2;
  localparam logic [2:0] ERR_ARITH  = 3'd3;
  localparam logic [2:0] ERR_OPCODE = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_EXEC,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

>>> hdl/stack_register_vm_executor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stack_register_vm_executor
// Executes one decoded VM instruction per input transaction.
// ----------------------------------------------------------------------------
// Usage: each input transaction (mode, reg_a, reg_b, immediate, target)
// carries one decoded instruction; each yields exactly one output
// transaction (next_ip, halted, error_code, show_valid, show_value).
// The register file and the stack live in synchronous memories with
// registered reads. The accept edge issues the reads, the next cycle
// (ST_READ) holds the read data, and ST_EXEC executes and writes back
// while loading the result register, shown in ST_OUT. Division first
// runs a radix-2 restoring divider in ST_DIV. A new item is accepted
// only in ST_IDLE, after the previous result has been taken, so the
// block takes no new item while one is in flight; a stalled receiver
// holds the result register and the block. Reset clears the stack
// pointer, the instruction pointer and sets the machine running; the
// register file is cleared through per-register valid bits, the stack
// needs no clearing.
// After a halt, error or invalid opcode, items return the held pointer
// with halted set until reset.
// ----------------------------------------------------------------------------
module stack_register_vm_executor #(
  parameter int STACK_DEPTH = srvm_pkg::STACK_DEPTH_DEF,
  parameter int NUM_REGS    = srvm_pkg::NUM_REGS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [5:0]         mode,
  input  wire logic [4:0]         reg_a,
  input  wire logic [4:0]         reg_b,
  input  wire logic signed [31:0] immediate,
  input  wire logic [31:0]        target,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [31:0]             next_ip,
  output logic                    halted,
  output logic [2:0]              error_code,
  output logic                    show_valid,
  output logic signed [31:0]      show_value
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int RAW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

  srvm_pkg::state_t state, state_next;

  // memories
  logic [31:0] regs [NUM_REGS];
  logic [NUM_REGS-1:0] reg_ok;
  logic [31:0] stk [STACK_DEPTH];
  logic [31:0] ra_q, rb_q, stk_q;

  // architectural state
  logic [SPW-1:0] sp;
  logic [31:0]    ip;
  logic           running;

  // latched instruction
  logic [5:0]  op;
  logic [4:0]  ia;
  logic [31:0] imm, tgt;
  logic        ra_in, rb_in, ra_okq, rb_okq;

  // divider
  logic [5:0]  dcnt;
  logic [31:0] dquo, drem, dden;
  logic        dneg;

  // read registers: issue reads on accept
  logic       acc;
  logic       stk_we, reg_we;
  logic [SAW-1:0] stk_wa;
  logic [31:0] stk_wd, reg_wd;
  logic [RAW-1:0] reg_wa;

  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (acc) begin
      ra_q  <= regs[reg_a[RAW-1:0]];
      rb_q  <= regs[reg_b[RAW-1:0]];
      stk_q <= stk[SAW'(sp - SPW'(1))];
    end
    if (stk_we) stk[stk_wa] <= stk_wd;
    if (reg_we) regs[reg_wa] <= reg_wd;
  end

  // register operand values (out-of-range or unwritten read as zero)
  logic [31:0] va, vb;
  assign va = (ra_in && ra_okq) ? ra_q : 32'd0;
  assign vb = (rb_in && rb_okq) ? rb_q : 32'd0;

  // combinational execute
  logic signed [32:0] addr, subr;
  logic signed [63:0] mulr;
  logic [31:0] rip, rsv, pushv;
  logic [2:0]  rerr;
  logic        rstop, rshow, dopush, dopop, regw;
  logic [31:0] regv;
  logic        sp_empty, sp_full;
  logic signed [31:0] divq;

  assign addr = $signed({va[31], va}) + $signed({vb[31], vb});
  assign subr = $signed({va[31], va}) - $signed({vb[31], vb});
  assign mulr = $signed(va) * $signed(vb);
  assign sp_empty = (sp == '0);
  assign sp_full  = (sp >= SP_FULL);
  assign divq = dneg ? -$signed(dquo) : $signed(dquo);

  always_comb begin
    rip = ip; rsv = 32'd0; rerr = srvm_pkg::ERR_NONE; rstop = 1'b0;
    rshow = 1'b0; dopush = 1'b0; dopop = 1'b0; regw = 1'b0; regv = imm;
    pushv = 32'd0;
    case (op)
      srvm_pkg::OP_HALT: rstop = 1'b1;
      srvm_pkg::OP_DISP: begin rshow = 1'b1; rsv = va; rip = ip + 32'd2; end
      srvm_pkg::OP_PSTK: rip = ip + 32'd2;
      srvm_pkg::OP_PUSH: begin
        rip = ip + 32'd2; pushv = va;
        if (sp_full) rerr = srvm_pkg::ERR_OVER; else dopush = 1'b1;
      end
      srvm_pkg::OP_POP: begin
        rip = ip + 32'd2;
        if (sp_empty) rerr = srvm_pkg::ERR_UNDER;
        else begin dopop = 1'b1; regw = 1'b1; regv = stk_q; end
      end
      srvm_pkg::OP_MOV: begin rip = ip + 32'd3; regw = 1'b1; regv = imm; end
      srvm_pkg::OP_CALL: begin
        rip = tgt; pushv = ip + 32'd2;
        if (sp_full) rerr = srvm_pkg::ERR_OVER; else dopush = 1'b1;
      end
      srvm_pkg::OP_RET: begin
        if (sp_empty) rerr = srvm_pkg::ERR_UNDER;
        else begin dopop = 1'b1; rip = stk_q; end
      end
      srvm_pkg::OP_JMP: rip = tgt;
      srvm_pkg::OP_JZ, srvm_pkg::OP_JPOS, srvm_pkg::OP_JNEG: begin
        if (sp_empty) rerr = srvm_pkg::ERR_UNDER;
        else begin
          dopop = 1'b1;
          if ((op == srvm_pkg::OP_JZ && stk_q == 32'd0) ||
              (op == srvm_pkg::OP_JPOS && !stk_q[31] && stk_q != 32'd0) ||
              (op == srvm_pkg::OP_JNEG && stk_q[31]))
            rip = tgt;
          else
            rip = ip + 32'd2;
        end
      end
      srvm_pkg::OP_ADD, srvm_pkg::OP_SUB, srvm_pkg::OP_MUL, srvm_pkg::OP_DIV: begin
        rip = ip + 32'd3;
        case (op)
          srvm_pkg::OP_ADD: begin
            pushv = addr[31:0];
            if (addr[32] != addr[31]) rerr = srvm_pkg::ERR_ARITH;
          end
          srvm_pkg::OP_SUB: begin
            pushv = subr[31:0];
            if (subr[32] != subr[31]) rerr = srvm_pkg::ERR_ARITH;
          end
          srvm_pkg::OP_MUL: begin
            pushv = mulr[31:0];
            if (mulr[63:31] != {33{mulr[31]}}) rerr = srvm_pkg::ERR_ARITH;
          end
          default: begin
            pushv = divq;
            if (vb == 32'd0 || (va == 32'h8000_0000 && vb == 32'hFFFF_FFFF))
              rerr = srvm_pkg::ERR_ARITH;
          end
        endcase
        if (rerr == srvm_pkg::ERR_NONE) begin
          if (sp_full) rerr = srvm_pkg::ERR_OVER; else dopush = 1'b1;
        end
      end
      default: begin rerr = srvm_pkg::ERR_OPCODE; rstop = 1'b1; end
    endcase
    if (rerr != srvm_pkg::ERR_NONE) rstop = 1'b1;
  end

  logic exec;
  assign exec   = (state == srvm_pkg::ST_EXEC);
  assign stk_we = exec && running && dopush;
  assign stk_wa = sp[SAW-1:0];
  assign stk_wd = pushv;
  assign reg_we = exec && running && regw && ra_in;
  assign reg_wa = ia[RAW-1:0];
  assign reg_wd = regv;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      srvm_pkg::ST_IDLE: if (in_valid) state_next = srvm_pkg::ST_READ;
      srvm_pkg::ST_READ:
        state_next = (running && op == srvm_pkg::OP_DIV) ? srvm_pkg::ST_DIV
                                                         : srvm_pkg::ST_EXEC;
      srvm_pkg::ST_DIV: if (dcnt == 6'd0) state_next = srvm_pkg::ST_EXEC;
      srvm_pkg::ST_EXEC: state_next = srvm_pkg::ST_OUT;
      srvm_pkg::ST_OUT: if (out_ready) state_next = srvm_pkg::ST_IDLE;
      default: state_next = srvm_pkg::ST_IDLE;
    endcase
  end

  assign in_ready  = (state == srvm_pkg::ST_IDLE);
  assign out_valid = (state == srvm_pkg::ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) state <= srvm_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // latch instruction
  always_ff @(posedge clk) begin
    if (acc) begin
      op <= mode; ia <= reg_a; imm <= immediate; tgt <= target;
      ra_in <= (32'(reg_a) < NUM_REGS);
      rb_in <= (32'(reg_b) < NUM_REGS);
      ra_okq <= reg_ok[reg_a[RAW-1:0]];
      rb_okq <= reg_ok[reg_b[RAW-1:0]];
    end
  end

  // divider on magnitudes, one quotient bit per cycle
  logic [32:0] dtrial;
  assign dtrial = {drem, dquo[31]} - {1'b0, dden};
  always_ff @(posedge clk) begin
    if (state == srvm_pkg::ST_READ) begin
      dcnt <= 6'd32;
      dquo <= va[31] ? -va : va;
      dden <= vb[31] ? -vb : vb;
      drem <= 32'd0;
      dneg <= va[31] ^ vb[31];
    end else if (state == srvm_pkg::ST_DIV && dcnt != 6'd0) begin
      dcnt <= dcnt - 6'd1;
      if (!dtrial[32]) begin
        drem <= dtrial[31:0];
        dquo <= {dquo[30:0], 1'b1};
      end else begin
        drem <= {drem[30:0], dquo[31]};
        dquo <= {dquo[30:0], 1'b0};
      end
    end
  end

  // commit architectural state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0; ip <= 32'd0; running <= 1'b1; reg_ok <= '0;
    end else if (exec && running) begin
      ip <= rip;
      if (rstop) running <= 1'b0;
      if (dopush) sp <= sp + SPW'(1);
      else if (dopop) sp <= sp - SPW'(1);
      if (reg_we) reg_ok[reg_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      if (running) begin
        next_ip <= rip; halted <= rstop; error_code <= rerr;
        show_valid <= rshow; show_value <= rsv;
      end else begin
        next_ip <= ip; halted <= 1'b1; error_code <= srvm_pkg::ERR_NONE;
        show_valid <= 1'b0; show_value <= 32'd0;
      end
    end
  end

  // checks
  a_sp_range: assert property (@(posedge clk) disable iff (rst) sp <= SP_FULL)
    else $error("stack pointer beyond depth");
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    !running |=> !running) else $error("machine restarted without reset");
  a_no_write_halted: assert property (@(posedge clk) disable iff (rst)
    !running |-> !stk_we && !reg_we) else $error("write while halted");
  a_show_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !show_valid |-> show_value == 32'd0)
    else $error("show_value set without show_valid");

endmodule
`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for stack_register_vm_executor: a scoreboard executes
// every accepted instruction on its own register file and stack and checks
// each output transaction; stimulus is directed, then constrained-by-state
// random, ending in one machine stop followed by items while halted.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;

  typedef struct {
    logic [31:0] ip;
    logic        halted;
    logic [2:0]  err;
    logic        shown;
    logic [31:0] value;
  } vm_result_t;

  class vm_scoreboard;
    logic [31:0] regs [srvm_pkg::NUM_REGS_DEF];
    logic [31:0] stk [$];
    logic [31:0] ip;
    bit          running;
    vm_result_t  pending [$];
    int          mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      ip = '0;
      running = 1'b1;
      mismatches = 0;
    endfunction

    function int depth();
      return stk.size();
    endfunction

    function logic [2:0] push_word(logic [31:0] w);
      if (stk.size() >= srvm_pkg::STACK_DEPTH_DEF) return srvm_pkg::ERR_OVER;
      stk.push_back(w);
      return srvm_pkg::ERR_NONE;
    endfunction

    function logic [2:0] pop_word(output logic [31:0] w);
      w = '0;
      if (stk.size() == 0) return srvm_pkg::ERR_UNDER;
      w = stk.pop_back();
      return srvm_pkg::ERR_NONE;
    endfunction

    // Compute an alu result; return 0 on overflow, zero divide or INT_MIN / -1
    function bit alu_eval(logic [5:0] m, logic [4:0] ia, logic [4:0] ib,
                          output logic [31:0] res);
      longint a;
      longint b;
      longint r;
      a = $signed(regs[ia]);
      b = $signed(regs[ib]);
      res = '0;
      case (m)
        srvm_pkg::OP_ADD: r = a + b;
        srvm_pkg::OP_SUB: r = a - b;
        srvm_pkg::OP_MUL: r = a * b;
        default: begin
          if (b == 0 || (a == -64'sd2147483648 && b == -1)) return 1'b0;
          r = a / b;
        end
      endcase
      if (r > 64'sd2147483647 || r < -64'sd2147483648) return 1'b0;
      res = r[31:0];
      return 1'b1;
    endfunction

    // Execute one accepted instruction and queue its expected result
    function void note_instruction(logic [5:0] m, logic [4:0] ra, logic [4:0] rb,
                                   logic [31:0] imm, logic [31:0] tgt);
      vm_result_t  e;
      logic [2:0]  err;
      logic [31:0] w;
      bit          take;
      err = srvm_pkg::ERR_NONE;
      e.shown = 1'b0;
      e.value = '0;
      if (running) begin
        case (m)
          srvm_pkg::OP_HALT: running = 1'b0;
          srvm_pkg::OP_DISP: begin
            e.shown = 1'b1;
            e.value = regs[ra];
            ip += 2;
          end
          srvm_pkg::OP_PSTK: ip += 2;
          srvm_pkg::OP_PUSH: begin
            err = push_word(regs[ra]);
            ip += 2;
          end
          srvm_pkg::OP_POP: begin
            err = pop_word(w);
            if (err == srvm_pkg::ERR_NONE) regs[ra] = w;
            ip += 2;
          end
          srvm_pkg::OP_MOV: begin
            regs[ra] = imm;
            ip += 3;
          end
          srvm_pkg::OP_CALL: begin
            w = ip + 2;
            ip = tgt;
            err = push_word(w);
          end
          srvm_pkg::OP_RET: begin
            err = pop_word(w);
            if (err == srvm_pkg::ERR_NONE) ip = w;
          end
          srvm_pkg::OP_JMP: ip = tgt;
          srvm_pkg::OP_JZ, srvm_pkg::OP_JPOS, srvm_pkg::OP_JNEG: begin
            err = pop_word(w);
            if (err == srvm_pkg::ERR_NONE) begin
              take = (m == srvm_pkg::OP_JZ) ? (w == 0) :
                     (m == srvm_pkg::OP_JPOS) ? ($signed(w) > 0) : ($signed(w) < 0);
              ip = take ? tgt : ip + 2;
            end
          end
          srvm_pkg::OP_ADD, srvm_pkg::OP_SUB, srvm_pkg::OP_MUL, srvm_pkg::OP_DIV: begin
            if (alu_eval(m, ra, rb, w)) err = push_word(w);
            else err = srvm_pkg::ERR_ARITH;
            ip += 3;
          end
          default: err = srvm_pkg::ERR_OPCODE;
        endcase
        if (err != srvm_pkg::ERR_NONE) running = 1'b0;
      end
      e.ip = ip;
      e.halted = !running;
      e.err = err;
      pending.push_back(e);
    endfunction

    // Compare one output transaction with the oldest expectation
    function void check_result(vm_result_t got);
      vm_result_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result ip=%h", got.ip);
        return;
      end
      e = pending.pop_front();
      if (got.ip !== e.ip || got.halted !== e.halted || got.err !== e.err ||
          got.shown !== e.shown || got.value !== e.value) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: exp ip=%h h=%b err=%0d sv=%b val=%h",
                    " / got ip=%h h=%b err=%0d sv=%b val=%h"},
                   e.ip, e.halted, e.err, e.shown, e.value,
                   got.ip, got.halted, got.err, got.shown, got.value);
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [5:0]        mode = '0;
  logic [4:0]        reg_a = '0;
  logic [4:0]        reg_b = '0;
  logic signed [31:0] immediate = '0;
  logic [31:0]       target = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [31:0]       next_ip;
  logic              halted;
  logic [2:0]        error_code;
  logic              show_valid;
  logic signed [31:0] show_value;

  vm_scoreboard sb = new();
  int  send_idle = 37;
  int  recv_idle = 62;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;
  int  quiet = 0;

  stack_register_vm_executor u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(mode), .reg_a(reg_a), .reg_b(reg_b),
    .immediate(immediate), .target(target),
    .out_valid(out_valid), .out_ready(out_ready),
    .next_ip(next_ip), .halted(halted), .error_code(error_code),
    .show_valid(show_valid), .show_value(show_value)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Drain output transactions; stall at random or hold off on request
  always @(posedge clk) begin
    vm_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.ip = next_ip;
      got.halted = halted;
      got.err = error_code;
      got.shown = show_valid;
      got.value = show_value;
      sb.check_result(got);
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("FAIL stack_register_vm_executor");
        $finish;
      end
    end
  end

  // Offer one instruction after an optional random gap; return once accepted
  task automatic send_instr(logic [5:0] m, logic [4:0] ra, logic [4:0] rb,
                            logic [31:0] imm, logic [31:0] tgt);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    reg_a <= ra;
    reg_b <= rb;
    immediate <= imm;
    target <= tgt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_instruction(m, ra, rb, imm, tgt);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Pick an instruction that keeps the machine running
  task automatic send_random();
    logic [5:0]  m;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [31:0] imm;
    logic [31:0] tgt;
    logic [31:0] unused;
    int          r;
    ra = 5'($urandom);
    rb = 5'($urandom);
    imm = $urandom_range(1) ? $urandom : $urandom_range(200) - 100;
    tgt = $urandom;
    r = $urandom_range(99);
    if (r < 20) m = srvm_pkg::OP_MOV;
    else if (r < 30) m = srvm_pkg::OP_DISP;
    else if (r < 35) m = srvm_pkg::OP_PSTK;
    else if (r < 50) m = srvm_pkg::OP_PUSH;
    else if (r < 58) m = srvm_pkg::OP_POP;
    else if (r < 63) m = srvm_pkg::OP_CALL;
    else if (r < 68) m = srvm_pkg::OP_RET;
    else if (r < 72) m = srvm_pkg::OP_JMP;
    else if (r < 82) m = srvm_pkg::OP_JZ + 6'($urandom_range(2));
    else m = srvm_pkg::OP_ADD + 6'($urandom_range(3));
    if ((m == srvm_pkg::OP_PUSH || m == srvm_pkg::OP_CALL) && sb.depth() > 64)
      m = srvm_pkg::OP_POP;
    if ((m inside {srvm_pkg::OP_POP, srvm_pkg::OP_RET, srvm_pkg::OP_JZ,
                   srvm_pkg::OP_JPOS, srvm_pkg::OP_JNEG}) && sb.depth() == 0)
      m = srvm_pkg::OP_PUSH;
    if (m >= srvm_pkg::OP_ADD && !sb.alu_eval(m, ra, rb, unused)) m = srvm_pkg::OP_DISP;
    send_instr(m, ra, rb, imm, tgt);
  endtask

  initial begin
    logic [5:0] bad;
    int         stop_kind;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, every operation but halt, taken and untaken branches
    send_instr(srvm_pkg::OP_MOV, 0, 0, 32'h7FFF_FFFF, 0);
    send_instr(srvm_pkg::OP_MOV, 31, 0, 32'h8000_0000, 0);
    send_instr(srvm_pkg::OP_MOV, 5, 0, -7, 0);
    send_instr(srvm_pkg::OP_MOV, 6, 0, 2, 0);
    send_instr(srvm_pkg::OP_DISP, 0, 0, 0, 0);
    send_instr(srvm_pkg::OP_DISP, 31, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_instr(srvm_pkg::OP_PSTK, 0, 0, 0, 0);
    send_instr(srvm_pkg::OP_PUSH, 0, 0, 0, 0);
    send_instr(srvm_pkg::OP_PUSH, 31, 0, 0, 0);
    send_instr(srvm_pkg::OP_POP, 3, 0, 0, 0);
    send_instr(srvm_pkg::OP_ADD, 5, 6, 0, 0);
    send_instr(srvm_pkg::OP_SUB, 5, 6, 0, 0);
    send_instr(srvm_pkg::OP_MUL, 5, 6, 0, 0);
    send_instr(srvm_pkg::OP_DIV, 5, 6, 0, 0);
    repeat (4) send_instr(srvm_pkg::OP_POP, 7, 0, 0, 0);
    send_instr(srvm_pkg::OP_JPOS, 0, 0, 0, 100);
    send_instr(srvm_pkg::OP_PUSH, 31, 0, 0, 0);
    send_instr(srvm_pkg::OP_JNEG, 0, 0, 0, 200);
    send_instr(srvm_pkg::OP_PUSH, 1, 0, 0, 0);
    send_instr(srvm_pkg::OP_JZ, 0, 0, 0, 300);
    send_instr(srvm_pkg::OP_CALL, 0, 0, 0, 32'hFFFF_FFFF);
    send_instr(srvm_pkg::OP_RET, 0, 0, 0, 0);
    send_instr(srvm_pkg::OP_JMP, 0, 0, 0, 32'hFFFF_FFFE);
    send_instr(srvm_pkg::OP_PSTK, 0, 0, 0, 0);
    send_instr(srvm_pkg::OP_PUSH, 6, 0, 0, 0);
    send_instr(srvm_pkg::OP_JZ, 0, 0, 0, 400);

    // Random, first phase
    repeat (400) send_random();
    wait_drained();

    // Random, roles of the two sides swapped
    send_idle = 62;
    recv_idle = 37;
    repeat (400) send_random();
    wait_drained();

    // Random with no idling; open with a long receiver hold-off
    send_idle = 0;
    recv_idle = 0;
    hold_req = 1'b1;
    repeat (400) send_random();
    wait_drained();

    // Stop the machine one way, then offer items while halted
    stop_kind = $urandom_range(4);
    case (stop_kind)
      0: send_instr(srvm_pkg::OP_HALT, 5'($urandom), 5'($urandom), $urandom, $urandom);
      1: begin
        send_instr(srvm_pkg::OP_MOV, 1, 0, 32'h7FFF_FFFF, 0);
        send_instr(srvm_pkg::OP_MOV, 2, 0, 32'd1, 0);
        send_instr(srvm_pkg::OP_ADD, 1, 2, 0, 0);
      end
      2: begin
        while (sb.depth() >= 0 && sb.running)
          send_instr(srvm_pkg::OP_POP, 5'($urandom), 0, 0, 0);
      end
      3: begin
        send_instr(srvm_pkg::OP_MOV, 1, 0, 32'h8000_0000, 0);
        send_instr(srvm_pkg::OP_MOV, 2, 0, 32'hFFFF_FFFF, 0);
        send_instr(srvm_pkg::OP_DIV, 1, 2, 0, 0);
      end
      default: begin
        do begin
          bad = 6'($urandom);
        end while (bad inside {[srvm_pkg::OP_HALT:srvm_pkg::OP_PSTK],
                               [srvm_pkg::OP_PUSH:srvm_pkg::OP_MOV],
                               [srvm_pkg::OP_CALL:srvm_pkg::OP_JNEG],
                               [srvm_pkg::OP_ADD:srvm_pkg::OP_DIV]});
        send_instr(bad, 5'($urandom), 5'($urandom), $urandom, $urandom);
      end
    endcase
    repeat (12) send_instr(6'($urandom), 5'($urandom), 5'($urandom), $urandom, $urandom);
    wait_drained();
    repeat (50) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("PASS stack_register_vm_executor");
    end else begin
      $display("FAIL stack_register_vm_executor");
    end
    $finish;
  end

endmodule

>>> stack_register_vm_executor.f
hdl/srvm_pkg.sv
hdl/stack_register_vm_executor.sv
sim/tb.sv
